FILE: hdl/two_hop_neighborhood_marker_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-hop neighborhood marker
// Shared concurrent assertion forms with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef TWO_HOP_NEIGHBORHOOD_MARKER_UNIT_ASSERT_SVH
`define TWO_HOP_NEIGHBORHOOD_MARKER_UNIT_ASSERT_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define THNM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent holds in the next cycle.
`define THNM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/thnm_pkg.sv
// ---------------------------------------------------------------------------
// Two-hop neighborhood marker package
// Sizes, operation codes and beat types of the marker unit.
// ---------------------------------------------------------------------------
package thnm_pkg;

    localparam int NODES  = 64;
    localparam int NODE_W = 6;
    localparam int CNT_W  = 7;
    localparam int ROW_W  = 64;
    localparam int POP_STEPS = ROW_W / 8;
    localparam int STEP_W = 3;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(NODES);

    typedef enum logic [1:0] {
        OP_SET_TIE   = 2'd0,
        OP_CLEAR_TIE = 2'd1,
        OP_EGO       = 2'd2,
        OP_QUERY     = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [NODE_W-1:0] first_node;
        logic [NODE_W-1:0] second_node;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] degree;
        logic              in_setting;
        logic              status;
    } t_out_item;

endpackage

FILE: hdl/two_hop_neighborhood_marker_unit.sv
// ---------------------------------------------------------------------------
// Two-hop neighborhood marker unit
// Keeps a directed graph as out-tie and in-tie row memories and marks the
// actors within two steps of an ego, ties taken in either direction.
// ---------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in       input      i_in_valid/o_in_stall   i_in_beat  (thnm_pkg::t_in_item)
//   out      output     o_out_valid/i_out_stall o_out_beat (thnm_pkg::t_out_item)
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_data (node_count)
//
// One beat is worked on at a time; the next is taken while a result waits.
// A tie update reads both rows, then writes them back; a query or flagged beat
// goes straight to its result. An ego setting scans all rows through the single
// read port of each row memory, then sizes the set with an 8-bit-per-cycle count.
// Reset empties the graph at once through per-row valid flops.
// ---------------------------------------------------------------------------
`include "two_hop_neighborhood_marker_unit_assert.svh"

module two_hop_neighborhood_marker_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  thnm_pkg::t_in_item   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output thnm_pkg::t_out_item  o_out_beat,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [thnm_pkg::CNT_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TIE_RD,
        S_TIE_WR,
        S_EGO_RD,
        S_EGO_FIRST,
        S_SCAN,
        S_COUNT,
        S_DONE
    } t_state;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

    t_state                        r_state;
    thnm_pkg::t_in_item            r_item;
    logic [thnm_pkg::CNT_W-1:0]    r_node_count;
    logic [thnm_pkg::ROW_W-1:0]    r_map;
    logic [thnm_pkg::NODE_W-1:0]   r_size;
    logic [thnm_pkg::ROW_W-1:0]    r_first;
    logic [thnm_pkg::ROW_W-1:0]    r_set;
    logic [thnm_pkg::ROW_W-1:0]    r_pop;
    logic [thnm_pkg::CNT_W-1:0]    r_acc;
    logic [thnm_pkg::STEP_W-1:0]   r_k;
    logic [thnm_pkg::CNT_W-1:0]    r_j;
    logic                          r_pend;
    logic                          r_res_member;
    logic                          r_res_flag;
    logic                          r_out_valid;
    thnm_pkg::t_out_item           r_out_item;

    logic [thnm_pkg::ROW_W-1:0]    mem_out [thnm_pkg::NODES];
    logic [thnm_pkg::ROW_W-1:0]    mem_in  [thnm_pkg::NODES];
    logic [thnm_pkg::NODES-1:0]    r_out_vld;
    logic [thnm_pkg::NODES-1:0]    r_in_vld;
    logic [thnm_pkg::ROW_W-1:0]    r_out_q;
    logic [thnm_pkg::ROW_W-1:0]    r_in_q;
    logic                          r_out_qv;
    logic                          r_in_qv;

    logic [thnm_pkg::CNT_W-1:0]    act_cnt;
    logic [thnm_pkg::ROW_W-1:0]    act_mask;
    logic                          in_accept;
    logic                          a_bad;
    logic                          b_bad;
    logic                          rd_en;
    logic [thnm_pkg::NODE_W-1:0]   rd_out_addr;
    logic [thnm_pkg::NODE_W-1:0]   rd_in_addr;
    logic                          wr_en;
    logic [thnm_pkg::ROW_W-1:0]    wr_out_data;
    logic [thnm_pkg::ROW_W-1:0]    wr_in_data;
    logic [thnm_pkg::ROW_W-1:0]    row_out;
    logic [thnm_pkg::ROW_W-1:0]    row_in;
    logic [thnm_pkg::ROW_W-1:0]    nbr_row;
    logic [thnm_pkg::ROW_W-1:0]    ego_bit;
    logic [thnm_pkg::ROW_W-1:0]    recv_bit;
    logic [thnm_pkg::ROW_W-1:0]    send_bit;
    logic [thnm_pkg::CNT_W-1:0]    acc_sum;
    logic                          out_free;

    assign act_cnt = (r_node_count > thnm_pkg::NODE_COUNT_RESET)
                   ? thnm_pkg::NODE_COUNT_RESET : r_node_count;

    always_comb begin
        for (int j = 0; j < thnm_pkg::ROW_W; j++) begin
            act_mask[j] = (thnm_pkg::CNT_W'(j) < act_cnt);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_item;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign a_bad = ({1'b0, i_in_beat.first_node} >= act_cnt);
    assign b_bad = ({1'b0, i_in_beat.second_node} >= act_cnt);

    assign row_out  = r_out_qv ? r_out_q : '0;
    assign row_in   = r_in_qv ? r_in_q : '0;
    assign nbr_row  = (row_out | row_in) & act_mask;
    assign ego_bit  = thnm_pkg::ROW_W'(1) << r_item.first_node;
    assign send_bit = ego_bit;
    assign recv_bit = thnm_pkg::ROW_W'(1) << r_item.second_node;
    assign acc_sum  = r_acc + thnm_pkg::CNT_W'(pop8(r_pop[7:0]));

    always_comb begin
        rd_en       = 1'b0;
        rd_out_addr = r_item.first_node;
        rd_in_addr  = r_item.first_node;
        case (r_state)
            S_TIE_RD: begin
                rd_en      = 1'b1;
                rd_in_addr = r_item.second_node;
            end
            S_EGO_RD: begin
                rd_en = 1'b1;
            end
            S_SCAN: begin
                rd_en       = (r_j < thnm_pkg::NODE_COUNT_RESET);
                rd_out_addr = r_j[thnm_pkg::NODE_W-1:0];
                rd_in_addr  = r_j[thnm_pkg::NODE_W-1:0];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign wr_en = (r_state == S_TIE_WR);

    always_comb begin
        if (r_item.op == thnm_pkg::OP_SET_TIE) begin
            wr_out_data = row_out | recv_bit;
            wr_in_data  = row_in | send_bit;
        end else begin
            wr_out_data = row_out & ~recv_bit;
            wr_in_data  = row_in & ~send_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_out[r_item.first_node] <= wr_out_data;
            mem_in[r_item.second_node] <= wr_in_data;
        end
        if (rd_en) begin
            r_out_q  <= mem_out[rd_out_addr];
            r_in_q   <= mem_in[rd_in_addr];
            r_out_qv <= r_out_vld[rd_out_addr];
            r_in_qv  <= r_in_vld[rd_in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= '0;
            r_in_vld  <= '0;
        end else if (wr_en) begin
            r_out_vld[r_item.first_node] <= 1'b1;
            r_in_vld[r_item.second_node] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= thnm_pkg::NODE_COUNT_RESET;
            r_map        <= '0;
            r_size       <= '0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
            r_j          <= '0;
            r_k          <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_item       <= i_in_beat;
                        r_res_member <= 1'b0;
                        r_res_flag   <= 1'b0;
                        case (i_in_beat.op)
                            thnm_pkg::OP_SET_TIE, thnm_pkg::OP_CLEAR_TIE: begin
                                if (a_bad || b_bad) begin
                                    r_res_flag <= 1'b1;
                                    r_state    <= S_DONE;
                                end else begin
                                    r_state <= S_TIE_RD;
                                end
                            end
                            thnm_pkg::OP_EGO: begin
                                if (a_bad) begin
                                    r_res_flag <= 1'b1;
                                    r_state    <= S_DONE;
                                end else begin
                                    r_state <= S_EGO_RD;
                                end
                            end
                            default: begin
                                r_res_flag   <= a_bad;
                                r_res_member <= !a_bad && r_map[i_in_beat.first_node];
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_TIE_RD: begin
                    r_state <= S_TIE_WR;
                end
                S_TIE_WR: begin
                    r_state <= S_DONE;
                end
                S_EGO_RD: begin
                    r_state <= S_EGO_FIRST;
                end
                S_EGO_FIRST: begin
                    r_first <= nbr_row;
                    r_set   <= nbr_row;
                    r_j     <= '0;
                    r_pend  <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_j <= r_j + thnm_pkg::CNT_W'(1);
                    end
                    r_pend <= rd_en;
                    if (r_pend) begin
                        if (r_first[0]) begin
                            r_set <= r_set | nbr_row;
                        end
                        r_first <= r_first >> 1;
                    end
                    if (!rd_en && !r_pend) begin
                        r_map   <= r_set & ~ego_bit;
                        r_pop   <= r_set & ~ego_bit;
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    r_acc <= acc_sum;
                    r_pop <= r_pop >> 8;
                    r_k   <= r_k + thnm_pkg::STEP_W'(1);
                    if (r_k == thnm_pkg::STEP_W'(thnm_pkg::POP_STEPS - 1)) begin
                        r_size  <= acc_sum[thnm_pkg::NODE_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out_item.degree     <= r_size;
                        r_out_item.in_setting <= r_res_member;
                        r_out_item.status     <= r_res_flag;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `THNM_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n,
        (r_state == S_DONE && r_out_valid && i_out_stall), (r_state == S_DONE),
        "result overwrote a waiting output beat")
    `THNM_ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n,
        (r_state == S_SCAN && !rd_en && !r_pend), (r_state == S_COUNT),
        "row scan did not hand over to the count")
    `THNM_ASSERT_NOW(a_ego_excluded, i_clk, i_rst_n,
        (r_state == S_COUNT), (!r_map[r_item.first_node]),
        "ego is marked in its own setting")
    `THNM_ASSERT_NEXT(a_size_matches, i_clk, i_rst_n,
        (r_state == S_COUNT && r_k == thnm_pkg::STEP_W'(thnm_pkg::POP_STEPS - 1)),
        (r_size == thnm_pkg::NODE_W'($countones(r_map))),
        "setting size differs from the marked actors")

endmodule

FILE: bench/tb_two_hop_neighborhood_marker_unit.sv
// ---------------------------------------------------------------------------
// Testbench for the two-hop neighborhood marker unit
// Sends tie updates, ego computations and actor queries under several actor
// counts, predicts every result beat from its own copy of the graph and
// compares each result field by field, with random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_two_hop_neighborhood_marker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic                         i_clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    thnm_pkg::t_in_item           in_beat = '0;
    logic                         out_stall = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic [thnm_pkg::CNT_W-1:0]   cfg_data = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    thnm_pkg::t_out_item          o_out_beat;
    logic                         o_cfg_ready;

    // Graph model and the last computed setting.
    logic [thnm_pkg::ROW_W-1:0]   out_ties [thnm_pkg::NODES];
    logic [thnm_pkg::ROW_W-1:0]   in_ties [thnm_pkg::NODES];
    logic [thnm_pkg::ROW_W-1:0]   setting_bits = '0;
    logic [thnm_pkg::NODE_W-1:0]  setting_count = '0;
    logic [thnm_pkg::CNT_W-1:0]   node_limit = thnm_pkg::NODE_COUNT_RESET;

    thnm_pkg::t_in_item           pending_items [$];
    thnm_pkg::t_out_item          expected_results [$];
    int unsigned       queued_items = 0;
    int unsigned       driven_items = 0;
    int unsigned       accepted_items = 0;
    int unsigned       gap_left = 0;
    int unsigned       gap_calm = 0;
    int unsigned       stall_left = 0;
    int unsigned       stall_calm = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       mismatch_count = 0;

    two_hop_neighborhood_marker_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned active_actors();
        return (node_limit > thnm_pkg::NODES) ? thnm_pkg::NODES : node_limit;
    endfunction

    function automatic int unsigned pick_idle(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 58) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic thnm_pkg::t_out_item apply_marker_beat(thnm_pkg::t_in_item beat);
        thnm_pkg::t_out_item        res;
        int unsigned                eff;
        logic [thnm_pkg::ROW_W-1:0] mask;
        logic [thnm_pkg::ROW_W-1:0] first_ring;
        logic [thnm_pkg::ROW_W-1:0] reach;
        int unsigned                a;
        int unsigned                b;
        eff = active_actors();
        mask = (eff >= thnm_pkg::ROW_W) ? '1
             : ((thnm_pkg::ROW_W'(1) << eff) - thnm_pkg::ROW_W'(1));
        a = beat.first_node;
        b = beat.second_node;
        res = '0;
        case (beat.op)
            thnm_pkg::OP_SET_TIE, thnm_pkg::OP_CLEAR_TIE: begin
                if (a >= eff || b >= eff) begin
                    res.status = 1'b1;
                end else begin
                    out_ties[a][b] = (beat.op == thnm_pkg::OP_SET_TIE);
                    in_ties[b][a]  = (beat.op == thnm_pkg::OP_SET_TIE);
                end
            end
            thnm_pkg::OP_EGO: begin
                if (a >= eff) begin
                    res.status = 1'b1;
                end else begin
                    first_ring = (out_ties[a] | in_ties[a]) & mask;
                    reach = first_ring;
                    for (int j = 0; j < eff; j++) begin
                        if (first_ring[j]) reach |= (out_ties[j] | in_ties[j]) & mask;
                    end
                    reach[a] = 1'b0;
                    setting_bits = reach;
                    setting_count = thnm_pkg::NODE_W'($countones(reach));
                end
            end
            default: begin
                if (a >= eff) res.status = 1'b1;
                else res.in_setting = setting_bits[a];
            end
        endcase
        res.degree = setting_count;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Driver: presents queued beats with random gaps.
    always @(negedge i_clk) begin
        logic               next_valid;
        thnm_pkg::t_in_item next_beat;
        next_valid = in_valid;
        next_beat  = in_beat;
        if (rst_n) begin
            if (in_valid && accepted_items == driven_items) next_valid = 1'b0;
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0) begin
                    next_beat  = pending_items.pop_front();
                    next_valid = 1'b1;
                    driven_items++;
                    gap_left = pick_idle(gap_calm);
                end
            end
        end
        in_valid <= next_valid;
        in_beat  <= next_beat;
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            stall_left = pick_idle(stall_calm);
            out_stall <= 1'b0;
        end
    end

    // Monitor: checks result beats, then predicts for the accepted input beat.
    always @(posedge i_clk) begin
        thnm_pkg::t_out_item want;
        if (rst_n) begin
            idle_cycles++;
            if (o_out_valid && !out_stall) begin
                idle_cycles = 0;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat, degree", 0, o_out_beat.degree);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_beat.degree !== want.degree)
                        report_mismatch("degree", want.degree, o_out_beat.degree);
                    if (o_out_beat.in_setting !== want.in_setting)
                        report_mismatch("in_setting", want.in_setting, o_out_beat.in_setting);
                    if (o_out_beat.status !== want.status)
                        report_mismatch("status", want.status, o_out_beat.status);
                end
            end
            if (in_valid && !o_in_stall) begin
                idle_cycles = 0;
                expected_results.push_back(apply_marker_beat(in_beat));
                accepted_items++;
            end
            if (cfg_valid && o_cfg_ready) idle_cycles = 0;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic add_item(input thnm_pkg::t_op op, input int unsigned a,
                            input int unsigned b);
        thnm_pkg::t_in_item beat;
        beat.op = op;
        beat.first_node = thnm_pkg::NODE_W'(a);
        beat.second_node = thnm_pkg::NODE_W'(b);
        pending_items.push_back(beat);
        queued_items++;
    endtask

    function automatic int unsigned pick_node(int unsigned eff);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (eff == 0 || r < 10) return $urandom_range(0, thnm_pkg::NODES - 1);
        if (r < 50) return $urandom_range(0, ((eff < 12) ? eff : 12) - 1);
        return $urandom_range(0, eff - 1);
    endfunction

    task automatic add_random(input int unsigned count);
        int unsigned eff;
        int unsigned r;
        eff = active_actors();
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                add_item(thnm_pkg::OP_SET_TIE, pick_node(eff), pick_node(eff));
            end else if (r < 60) begin
                add_item(thnm_pkg::OP_CLEAR_TIE, pick_node(eff), pick_node(eff));
            end else if (r < 78) begin
                add_item(thnm_pkg::OP_EGO, pick_node(eff),
                         $urandom_range(0, thnm_pkg::NODES - 1));
            end else begin
                add_item(thnm_pkg::OP_QUERY, pick_node(eff),
                         $urandom_range(0, thnm_pkg::NODES - 1));
            end
        end
    endtask

    // Returns once every queued beat is taken and every result has arrived.
    task automatic wait_idle();
        while (accepted_items != queued_items || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_node_count(input logic [thnm_pkg::CNT_W-1:0] value);
        @(negedge i_clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        node_limit = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < thnm_pkg::NODES; i++) begin
            out_ties[i] = '0;
            in_ties[i]  = '0;
        end
        repeat (9) @(negedge i_clk);
        rst_n <= 1'b1;

        write_node_count(7'd64);
        add_item(thnm_pkg::OP_SET_TIE, 0, 1);
        add_item(thnm_pkg::OP_SET_TIE, 1, 2);
        add_item(thnm_pkg::OP_SET_TIE, 5, 0);
        add_item(thnm_pkg::OP_SET_TIE, 2, 2);
        add_item(thnm_pkg::OP_SET_TIE, 63, 62);
        add_item(thnm_pkg::OP_SET_TIE, 40, 63);
        add_item(thnm_pkg::OP_EGO, 0, 63);
        add_item(thnm_pkg::OP_QUERY, 2, 0);
        add_item(thnm_pkg::OP_QUERY, 63, 63);
        add_item(thnm_pkg::OP_QUERY, 0, 0);
        add_item(thnm_pkg::OP_CLEAR_TIE, 1, 2);
        add_item(thnm_pkg::OP_EGO, 0, 0);
        add_item(thnm_pkg::OP_EGO, 63, 0);
        add_item(thnm_pkg::OP_SET_TIE, 63, 63);
        add_item(thnm_pkg::OP_EGO, 63, 63);
        add_item(thnm_pkg::OP_QUERY, 40, 0);
        add_item(thnm_pkg::OP_CLEAR_TIE, 63, 62);
        add_item(thnm_pkg::OP_CLEAR_TIE, 63, 62);
        add_item(thnm_pkg::OP_QUERY, 62, 0);
        add_random(200);
        wait_idle();

        write_node_count(7'd4);
        add_item(thnm_pkg::OP_SET_TIE, 3, 5);
        add_item(thnm_pkg::OP_SET_TIE, 5, 3);
        add_item(thnm_pkg::OP_SET_TIE, 0, 3);
        add_item(thnm_pkg::OP_EGO, 4, 0);
        add_item(thnm_pkg::OP_EGO, 0, 63);
        add_item(thnm_pkg::OP_QUERY, 62, 0);
        add_item(thnm_pkg::OP_QUERY, 3, 0);
        add_random(60);
        wait_idle();

        write_node_count(7'd0);
        add_item(thnm_pkg::OP_SET_TIE, 0, 0);
        add_item(thnm_pkg::OP_CLEAR_TIE, 0, 0);
        add_item(thnm_pkg::OP_EGO, 0, 0);
        add_item(thnm_pkg::OP_QUERY, 0, 0);
        add_random(10);
        wait_idle();

        write_node_count(7'd127);
        add_random(100);
        wait_idle();

        write_node_count(7'd1);
        add_random(30);
        wait_idle();

        write_node_count(7'd2);
        add_random(40);
        wait_idle();

        repeat (2) begin
            write_node_count(thnm_pkg::CNT_W'($urandom_range(1, thnm_pkg::NODES)));
            add_random(100);
            wait_idle();
        end

        write_node_count(7'd64);
        add_random(150);
        wait_idle();

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
